/* hw/rtl/cbz_pkg.sv */
// ----------------------------------------------------------------------------
// cbz_pkg: shared types and constants for the cubic Bezier evaluator
// Fixed-point widths, weight split points and the stage payload structs.
// ----------------------------------------------------------------------------
package cbz_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int T_FRAC_BITS  = 16;

   localparam int T_WIDTH      = T_FRAC_BITS + 1;
   localparam int SQ_WIDTH     = 2 * T_FRAC_BITS + 1;
   localparam int WT_WIDTH     = 3 * T_FRAC_BITS + 1;
   localparam int WLO_WIDTH    = (WT_WIDTH + 1) / 2;
   localparam int WHI_WIDTH    = WT_WIDTH - WLO_WIDTH;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;

   localparam int PLO_WIDTH    = COORD_WIDTH + WLO_WIDTH + 1;
   localparam int PHI_WIDTH    = COORD_WIDTH + WHI_WIDTH + 1;
   localparam int SLP_WIDTH    = DIFF_WIDTH + SQ_WIDTH + 1;

   localparam int LO_SUM_WIDTH = PLO_WIDTH + 2;
   localparam int HI_SUM_WIDTH = PHI_WIDTH + 2;
   localparam int SL_SUM_WIDTH = SLP_WIDTH + 2;

   localparam int PT_ACC_WIDTH = HI_SUM_WIDTH + WLO_WIDTH + 1;
   localparam int SL_ACC_WIDTH = SL_SUM_WIDTH + 3;

   localparam int PT_SHIFT     = 3 * T_FRAC_BITS;
   localparam int SL_SHIFT     = 2 * T_FRAC_BITS;
   localparam int PT_RND_WIDTH = PT_ACC_WIDTH - PT_SHIFT;
   localparam int SL_RND_WIDTH = SL_ACC_WIDTH - SL_SHIFT;

   localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;

   // one half in the final scale, added ahead of the floor shift
   localparam logic [PT_ACC_WIDTH-1:0] PT_HALF = PT_ACC_WIDTH'(1) << (PT_SHIFT - 1);
   localparam logic [SL_ACC_WIDTH-1:0] SL_HALF = SL_ACC_WIDTH'(1) << (SL_SHIFT - 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PLO_WIDTH-1:0]   plo_type;
   typedef logic signed [PHI_WIDTH-1:0]   phi_type;
   typedef logic signed [SLP_WIDTH-1:0]   slp_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   // control points, tangent differences and Bernstein weights
   typedef struct packed {
      coord_type [3:0]                px;
      coord_type [3:0]                py;
      diff_type  [2:0]                dx;
      diff_type  [2:0]                dy;
      logic      [3:0][WT_WIDTH-1:0]  wpt;
      logic      [2:0][SQ_WIDTH-1:0]  wsl;
   } weights_type;

   // partial products: point weights split in a low and a high half
   typedef struct packed {
      plo_type [3:0] lo_x;
      plo_type [3:0] lo_y;
      phi_type [3:0] hi_x;
      phi_type [3:0] hi_y;
      slp_type [2:0] sl_x;
      slp_type [2:0] sl_y;
   } products_type;

   // exact sums with the rounding half already added
   typedef struct packed {
      logic signed [PT_ACC_WIDTH-1:0] pt_x;
      logic signed [PT_ACC_WIDTH-1:0] pt_y;
      logic signed [SL_ACC_WIDTH-1:0] sl_x;
      logic signed [SL_ACC_WIDTH-1:0] sl_y;
   } acc_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type slope_x;
      coord_type slope_y;
   } result_type;

endpackage

/* hw/rtl/cubic_bezier_point_tangent.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_tangent: cubic Bezier point and tangent evaluator
// Throughput: one beat per cycle while rsp_stall is low; six register stages
//   (squares, weights, 32x25 and 32x24 partial products, two adder stages,
//   round/saturate) set the depth.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module cubic_bezier_point_tangent (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p3_y,
   input  logic        [cbz_pkg::T_WIDTH-1:0]     req_t_param,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_slope_x,
   output logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_slope_y
);
   import cbz_pkg::*;

   // Datapath overview
   //   front : clamp t to one, form u = 1 - t, then t^2, u^2, t*u and the
   //           differences p1-p0, p2-p1, p3-p2; next stage builds the four
   //           point weights u^3, 3u^2t, 3ut^2, t^3 and the tangent weights
   //           u^2, 2tu, t^2.
   //   mul   : each coordinate times the low and high halves of its weight,
   //           each difference times its tangent weight.
   //   sum   : add the halves separately, recombine, scale the tangent by
   //           three and add one half of the final LSB.
   //   round : drop the fraction bits (floor) and clamp to 32 bits.
   // Every product and sum is exact, so rounding happens once at the end.
   //
   // Flow control: every stage has its own valid bit and loads when it is
   // empty or when its content advances, so bubbles collapse and the input
   // keeps flowing into empty stages while a finished result waits at the output.

   coord_type [3:0] req_px;
   coord_type [3:0] req_py;
   weights_type     wt_data;
   products_type    pr_data;
   acc_type         ac_data;
   result_type      rs_data;
   logic            front_ready;
   logic            wt_valid;
   logic            mul_ready;
   logic            pr_valid;
   logic            sum_ready;
   logic            ac_valid;
   logic            round_ready;

   assign req_px = {req_p3_x, req_p2_x, req_p1_x, req_p0_x};
   assign req_py = {req_p3_y, req_p2_y, req_p1_y, req_p0_y};

   // hold off the producer only when the first stage cannot take a beat
   assign req_stall = !front_ready;

   cbz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_px     (req_px),
      .in_py     (req_py),
      .in_t      (req_t_param),
      .out_valid (wt_valid),
      .out_ready (mul_ready),
      .out_data  (wt_data)
   );

   cbz_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wt_valid),
      .in_ready  (mul_ready),
      .in_data   (wt_data),
      .out_valid (pr_valid),
      .out_ready (sum_ready),
      .out_data  (pr_data)
   );

   cbz_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pr_valid),
      .in_ready  (sum_ready),
      .in_data   (pr_data),
      .out_valid (ac_valid),
      .out_ready (round_ready),
      .out_data  (ac_data)
   );

   cbz_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ac_valid),
      .in_ready  (round_ready),
      .in_data   (ac_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rs_data)
   );

   // result beat straight from the output register
   assign rsp_point_x = rs_data.point_x;
   assign rsp_point_y = rs_data.point_y;
   assign rsp_slope_x = rs_data.slope_x;
   assign rsp_slope_y = rs_data.slope_y;

endmodule

/* hw/rtl/cbz_front.sv */
// ----------------------------------------------------------------------------
// cbz_front: parameter clamp, squares and Bernstein weights
// Two register stages: t, u and their squares, then the cubic weights.
// ----------------------------------------------------------------------------
module cbz_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  cbz_pkg::coord_type [3:0]     in_px,
   input  cbz_pkg::coord_type [3:0]     in_py,
   input  logic [cbz_pkg::T_WIDTH-1:0]  in_t,
   output logic                         out_valid,
   input  logic                         out_ready,
   output cbz_pkg::weights_type         out_data
);
   import cbz_pkg::*;

   typedef struct packed {
      logic      [T_WIDTH-1:0]  t;
      logic      [T_WIDTH-1:0]  u;
      logic      [SQ_WIDTH-1:0] t2;
      logic      [SQ_WIDTH-1:0] u2;
      logic      [SQ_WIDTH-1:0] tu;
      coord_type [3:0]          px;
      coord_type [3:0]          py;
      diff_type  [2:0]          dx;
      diff_type  [2:0]          dy;
   } square_type;

   square_type          sq_in;
   square_type          sq_ff;
   weights_type         wt_in;
   weights_type         wt_ff;
   logic                sq_valid_ff;
   logic                wt_valid_ff;
   logic                sq_load;
   logic                wt_load;
   logic [T_WIDTH-1:0]  t_clamp;
   logic [T_WIDTH-1:0]  u_val;
   logic [SQ_WIDTH-1:0] t_sq;
   logic [SQ_WIDTH-1:0] u_sq;
   logic [WT_WIDTH-1:0] u2_wt;
   logic [WT_WIDTH-1:0] t2_wt;
   logic [WT_WIDTH-1:0] t_wt;
   logic [WT_WIDTH-1:0] u_wt;
   logic [WT_WIDTH-1:0] u2t;
   logic [WT_WIDTH-1:0] t2u;

   // a stage takes a new beat when empty or when its content moves on
   assign wt_load   = !wt_valid_ff || out_ready;
   assign sq_load   = !sq_valid_ff || wt_load;
   assign in_ready  = sq_load;
   assign out_valid = wt_valid_ff;
   assign out_data  = wt_ff;

   always_comb begin
      t_clamp  = (in_t > T_ONE) ? T_ONE : in_t;
      u_val    = T_ONE - t_clamp;
      t_sq     = SQ_WIDTH'(t_clamp);
      u_sq     = SQ_WIDTH'(u_val);
      sq_in.t  = t_clamp;
      sq_in.u  = u_val;
      sq_in.t2 = t_sq * t_sq;
      sq_in.u2 = u_sq * u_sq;
      sq_in.tu = t_sq * u_sq;
      sq_in.px = in_px;
      sq_in.py = in_py;
      for (int i = 0; i < 3; i++) begin
         sq_in.dx[i] = DIFF_WIDTH'($signed(in_px[i + 1])) - DIFF_WIDTH'($signed(in_px[i]));
         sq_in.dy[i] = DIFF_WIDTH'($signed(in_py[i + 1])) - DIFF_WIDTH'($signed(in_py[i]));
      end
   end

   always_comb begin
      u2_wt      = WT_WIDTH'(sq_ff.u2);
      t2_wt      = WT_WIDTH'(sq_ff.t2);
      t_wt       = WT_WIDTH'(sq_ff.t);
      u_wt       = WT_WIDTH'(sq_ff.u);
      u2t        = u2_wt * t_wt;
      t2u        = t2_wt * u_wt;
      wt_in.px   = sq_ff.px;
      wt_in.py   = sq_ff.py;
      wt_in.dx   = sq_ff.dx;
      wt_in.dy   = sq_ff.dy;
      wt_in.wpt[0] = u2_wt * u_wt;
      wt_in.wpt[1] = u2t + (u2t << 1);
      wt_in.wpt[2] = t2u + (t2u << 1);
      wt_in.wpt[3] = t2_wt * t_wt;
      wt_in.wsl[0] = sq_ff.u2;
      wt_in.wsl[1] = sq_ff.tu << 1;
      wt_in.wsl[2] = sq_ff.t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         wt_valid_ff <= 1'b0;
      end else begin
         if (sq_load) begin
            sq_valid_ff <= in_valid;
         end
         if (wt_load) begin
            wt_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_load && in_valid) begin
         sq_ff <= sq_in;
      end
      if (wt_load && sq_valid_ff) begin
         wt_ff <= wt_in;
      end
   end

endmodule

/* hw/rtl/cbz_mul.sv */
// ----------------------------------------------------------------------------
// cbz_mul: coordinate by weight products
// One register stage of partial products; each point weight is cut in two.
// ----------------------------------------------------------------------------
module cbz_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cbz_pkg::weights_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cbz_pkg::products_type out_data
);
   import cbz_pkg::*;

   products_type pr_in;
   products_type pr_ff;
   logic         pr_valid_ff;
   logic         pr_load;

   assign pr_load   = !pr_valid_ff || out_ready;
   assign in_ready  = pr_load;
   assign out_valid = pr_valid_ff;
   assign out_data  = pr_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pr_in.lo_x[i] = PLO_WIDTH'($signed(in_data.px[i]))
                       * PLO_WIDTH'($signed({1'b0, in_data.wpt[i][WLO_WIDTH-1:0]}));
         pr_in.lo_y[i] = PLO_WIDTH'($signed(in_data.py[i]))
                       * PLO_WIDTH'($signed({1'b0, in_data.wpt[i][WLO_WIDTH-1:0]}));
         pr_in.hi_x[i] = PHI_WIDTH'($signed(in_data.px[i]))
                       * PHI_WIDTH'($signed({1'b0, in_data.wpt[i][WT_WIDTH-1:WLO_WIDTH]}));
         pr_in.hi_y[i] = PHI_WIDTH'($signed(in_data.py[i]))
                       * PHI_WIDTH'($signed({1'b0, in_data.wpt[i][WT_WIDTH-1:WLO_WIDTH]}));
      end
      for (int i = 0; i < 3; i++) begin
         pr_in.sl_x[i] = SLP_WIDTH'($signed(in_data.dx[i]))
                       * SLP_WIDTH'($signed({1'b0, in_data.wsl[i]}));
         pr_in.sl_y[i] = SLP_WIDTH'($signed(in_data.dy[i]))
                       * SLP_WIDTH'($signed({1'b0, in_data.wsl[i]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (pr_load) begin
         pr_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pr_load && in_valid) begin
         pr_ff <= pr_in;
      end
   end

endmodule

/* hw/rtl/cbz_sum.sv */
// ----------------------------------------------------------------------------
// cbz_sum: exact accumulation of the partial products
// Two register stages: per-half sums, then recombine and add the half.
// ----------------------------------------------------------------------------
module cbz_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cbz_pkg::products_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cbz_pkg::acc_type      out_data
);
   import cbz_pkg::*;

   typedef struct packed {
      logic signed [LO_SUM_WIDTH-1:0] lo_x;
      logic signed [LO_SUM_WIDTH-1:0] lo_y;
      logic signed [HI_SUM_WIDTH-1:0] hi_x;
      logic signed [HI_SUM_WIDTH-1:0] hi_y;
      logic signed [SL_SUM_WIDTH-1:0] sl_x;
      logic signed [SL_SUM_WIDTH-1:0] sl_y;
   } sums_type;

   sums_type                       sm_in;
   sums_type                       sm_ff;
   acc_type                        ac_in;
   acc_type                        ac_ff;
   logic                           sm_valid_ff;
   logic                           ac_valid_ff;
   logic                           sm_load;
   logic                           ac_load;
   logic signed [SL_ACC_WIDTH-1:0] sl_wx;
   logic signed [SL_ACC_WIDTH-1:0] sl_wy;

   assign ac_load   = !ac_valid_ff || out_ready;
   assign sm_load   = !sm_valid_ff || ac_load;
   assign in_ready  = sm_load;
   assign out_valid = ac_valid_ff;
   assign out_data  = ac_ff;

   always_comb begin
      sm_in = '0;
      for (int i = 0; i < 4; i++) begin
         sm_in.lo_x = sm_in.lo_x + LO_SUM_WIDTH'($signed(in_data.lo_x[i]));
         sm_in.lo_y = sm_in.lo_y + LO_SUM_WIDTH'($signed(in_data.lo_y[i]));
         sm_in.hi_x = sm_in.hi_x + HI_SUM_WIDTH'($signed(in_data.hi_x[i]));
         sm_in.hi_y = sm_in.hi_y + HI_SUM_WIDTH'($signed(in_data.hi_y[i]));
      end
      for (int i = 0; i < 3; i++) begin
         sm_in.sl_x = sm_in.sl_x + SL_SUM_WIDTH'($signed(in_data.sl_x[i]));
         sm_in.sl_y = sm_in.sl_y + SL_SUM_WIDTH'($signed(in_data.sl_y[i]));
      end
   end

   // recombine the two halves, scale the tangent by three, add one half
   always_comb begin
      sl_wx = SL_ACC_WIDTH'($signed(sm_ff.sl_x));
      sl_wy = SL_ACC_WIDTH'($signed(sm_ff.sl_y));
      ac_in.pt_x = PT_ACC_WIDTH'($signed(sm_ff.lo_x))
                 + (PT_ACC_WIDTH'($signed(sm_ff.hi_x)) <<< WLO_WIDTH)
                 + $signed(PT_HALF);
      ac_in.pt_y = PT_ACC_WIDTH'($signed(sm_ff.lo_y))
                 + (PT_ACC_WIDTH'($signed(sm_ff.hi_y)) <<< WLO_WIDTH)
                 + $signed(PT_HALF);
      ac_in.sl_x = sl_wx + (sl_wx <<< 1) + $signed(SL_HALF);
      ac_in.sl_y = sl_wy + (sl_wy <<< 1) + $signed(SL_HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_valid_ff <= 1'b0;
         ac_valid_ff <= 1'b0;
      end else begin
         if (sm_load) begin
            sm_valid_ff <= in_valid;
         end
         if (ac_load) begin
            ac_valid_ff <= sm_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sm_load && in_valid) begin
         sm_ff <= sm_in;
      end
      if (ac_load && sm_valid_ff) begin
         ac_ff <= ac_in;
      end
   end

endmodule

/* hw/rtl/cbz_round.sv */
// ----------------------------------------------------------------------------
// cbz_round: floor shift, saturation and the result register
// Last stage; holds the result beat while the consumer stalls.
// ----------------------------------------------------------------------------
module cbz_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cbz_pkg::acc_type    in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output cbz_pkg::result_type out_data
);
   import cbz_pkg::*;

   result_type                          rs_in;
   result_type                          rs_ff;
   logic                                rs_valid_ff;
   logic                                rs_load;
   logic [1:0][PT_RND_WIDTH-1:0]        pt_r;
   logic [1:0][SL_RND_WIDTH-1:0]        sl_r;
   logic [1:0][PT_RND_WIDTH-COORD_WIDTH:0] pt_top;
   logic [1:0][SL_RND_WIDTH-COORD_WIDTH:0] sl_top;
   coord_type [1:0]                     pt_sat;
   coord_type [1:0]                     sl_sat;

   assign rs_load   = !rs_valid_ff || !out_stall;
   assign in_ready  = rs_load;
   assign out_valid = rs_valid_ff;
   assign out_data  = rs_ff;

   always_comb begin
      // dropping the low bits is the floor shift
      pt_r[0] = in_data.pt_x[PT_ACC_WIDTH-1:PT_SHIFT];
      pt_r[1] = in_data.pt_y[PT_ACC_WIDTH-1:PT_SHIFT];
      sl_r[0] = in_data.sl_x[SL_ACC_WIDTH-1:SL_SHIFT];
      sl_r[1] = in_data.sl_y[SL_ACC_WIDTH-1:SL_SHIFT];
      for (int a = 0; a < 2; a++) begin
         pt_top[a] = pt_r[a][PT_RND_WIDTH-1:COORD_WIDTH-1];
         sl_top[a] = sl_r[a][SL_RND_WIDTH-1:COORD_WIDTH-1];
         if ((&pt_top[a]) || !(|pt_top[a])) begin
            pt_sat[a] = pt_r[a][COORD_WIDTH-1:0];
         end else begin
            pt_sat[a] = pt_r[a][PT_RND_WIDTH-1] ? COORD_MIN : COORD_MAX;
         end
         if ((&sl_top[a]) || !(|sl_top[a])) begin
            sl_sat[a] = sl_r[a][COORD_WIDTH-1:0];
         end else begin
            sl_sat[a] = sl_r[a][SL_RND_WIDTH-1] ? COORD_MIN : COORD_MAX;
         end
      end
      rs_in.point_x = pt_sat[0];
      rs_in.point_y = pt_sat[1];
      rs_in.slope_x = sl_sat[0];
      rs_in.slope_y = sl_sat[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_valid_ff <= 1'b0;
      end else if (rs_load) begin
         rs_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rs_load && in_valid) begin
         rs_ff <= rs_in;
      end
   end

endmodule

/* hw/rtl/cbz_check.sv */
// ----------------------------------------------------------------------------
// cbz_check: port-level checks for the Bezier evaluator
// Reset, output hold under stall and exact endpoint results.
// ----------------------------------------------------------------------------
module cbz_check (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p0_x,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p0_y,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p3_x,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] req_p3_y,
   input logic        [cbz_pkg::T_WIDTH-1:0]     req_t_param,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_point_x,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_point_y,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_slope_x,
   input logic signed [cbz_pkg::COORD_WIDTH-1:0] rsp_slope_y
);
   import cbz_pkg::*;

   logic start_beat;
   logic end_beat;
   logic moving;

   assign start_beat = req_valid && !req_stall && !reset && (req_t_param == '0);
   assign end_beat   = req_valid && !req_stall && !reset && (req_t_param >= T_ONE);
   assign moving     = !rsp_stall && !reset;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y)
         && $stable(rsp_slope_x) && $stable(rsp_slope_y))
      else $error("stalled result beat changed");

   a_start_point: assert property (@(posedge clock) disable iff (reset)
      $past(start_beat, 6) && $past(moving, 1) && $past(moving, 2) && $past(moving, 3)
         && $past(moving, 4) && $past(moving, 5)
      |-> rsp_valid && rsp_point_x == $past(req_p0_x, 6) && rsp_point_y == $past(req_p0_y, 6))
      else $error("point at t of zero is not the start point");

   a_end_point: assert property (@(posedge clock) disable iff (reset)
      $past(end_beat, 6) && $past(moving, 1) && $past(moving, 2) && $past(moving, 3)
         && $past(moving, 4) && $past(moving, 5)
      |-> rsp_valid && rsp_point_x == $past(req_p3_x, 6) && rsp_point_y == $past(req_p3_y, 6))
      else $error("point at t of one is not the end point");

endmodule

bind cubic_bezier_point_tangent cbz_check u_cbz_check (.*);
